>>> rtl/egsd_pkg.sv
// ----------------------------------------------------------------------------
// egsd_pkg
// Shared types and constants for the order-0 Exp-Golomb stream decoder.
// ----------------------------------------------------------------------------
package egsd_pkg;

  localparam int VALUE_WIDTH_DEF = 32;
  localparam int OUT_WIDTH       = 32;
  localparam int ZCNT_WIDTH      = 5;
  localparam logic [ZCNT_WIDTH-1:0] MAX_PREFIX_RESET = 5'd31;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_PREFIX = 2'd1,
    ST_TRUNC  = 2'd2
  } status_t;

  // One step request for the bit decoder.
  typedef struct packed {
    logic bit_step;   // consume one stream bit
    logic eos_step;   // close the stream after the last bit of the byte
    logic bit_val;
  } ctl_t;

  // Result event raised by a step.
  typedef struct packed {
    logic    valid;
    status_t status;
  } evt_t;

endpackage

>>> rtl/egsd_bit_dec.sv
// ----------------------------------------------------------------------------
// egsd_bit_dec
// Bit-serial Exp-Golomb decode core: counts prefix zeros and shifts in suffix
// bits one per step. The accumulator holds 2^z + suffix, so code = acc - 1.
// ----------------------------------------------------------------------------
module egsd_bit_dec #(
  parameter int VALUE_WIDTH = egsd_pkg::VALUE_WIDTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  egsd_pkg::ctl_t                     ctl,
  input  logic [egsd_pkg::ZCNT_WIDTH-1:0]    limit,
  output egsd_pkg::evt_t                     evt,
  output logic [VALUE_WIDTH-1:0]             res_acc
);

  logic                            in_suffix;
  logic                            in_suffix_next;
  logic [egsd_pkg::ZCNT_WIDTH-1:0] zero_count;
  logic [egsd_pkg::ZCNT_WIDTH-1:0] zero_count_next;
  logic [egsd_pkg::ZCNT_WIDTH-1:0] suffix_left;
  logic [egsd_pkg::ZCNT_WIDTH-1:0] suffix_left_next;
  logic [VALUE_WIDTH-1:0]          acc;
  logic [VALUE_WIDTH-1:0]          acc_next;
  logic [VALUE_WIDTH-1:0]          acc_shift;

  assign acc_shift = {acc[VALUE_WIDTH-2:0], ctl.bit_val};

  always_comb begin
    in_suffix_next   = in_suffix;
    zero_count_next  = zero_count;
    suffix_left_next = suffix_left;
    acc_next         = acc;
    evt.valid        = 1'b0;
    evt.status       = egsd_pkg::ST_OK;
    res_acc          = acc;
    if (ctl.bit_step) begin
      if (in_suffix) begin
        acc_next         = acc_shift;
        suffix_left_next = suffix_left - 1'b1;
        if (suffix_left == egsd_pkg::ZCNT_WIDTH'(1)) begin
          evt.valid       = 1'b1;
          res_acc         = acc_shift;
          in_suffix_next  = 1'b0;
          zero_count_next = '0;
        end
      end else if (!ctl.bit_val) begin
        if (zero_count >= limit) begin
          // prefix too long: drop the run and restart at the next bit
          evt.valid       = 1'b1;
          evt.status      = egsd_pkg::ST_PREFIX;
          zero_count_next = '0;
        end else begin
          zero_count_next = zero_count + 1'b1;
        end
      end else if (zero_count == '0) begin
        evt.valid = 1'b1;
        res_acc   = VALUE_WIDTH'(1);
      end else begin
        in_suffix_next   = 1'b1;
        suffix_left_next = zero_count;
        acc_next         = VALUE_WIDTH'(1);
      end
    end else if (ctl.eos_step) begin
      if (in_suffix || (zero_count != '0)) begin
        evt.valid  = 1'b1;
        evt.status = egsd_pkg::ST_TRUNC;
      end
      in_suffix_next   = 1'b0;
      zero_count_next  = '0;
      suffix_left_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_suffix   <= 1'b0;
      zero_count  <= '0;
      suffix_left <= '0;
    end else begin
      in_suffix   <= in_suffix_next;
      zero_count  <= zero_count_next;
      suffix_left <= suffix_left_next;
    end
    acc <= acc_next;
  end

endmodule

>>> rtl/exp_golomb_stream_decoder.sv
// Steps: after a byte is accepted it goes through eight bit steps in the serial
// decode core, one end-of-byte step and one flush of the last result.
// A new byte is taken only once the last one is flushed; a result held at the
// output stalls the bit steps until it is taken.
// Reset (rst, synchronous, active high) clears the decoder state, empties the
// result registers and restores max_prefix_zeros to 31.
// ----------------------------------------------------------------------------
// exp_golomb_stream_decoder
// Byte-fed order-0 Exp-Golomb decoder giving ue(v) and se(v) per finished code.
// ----------------------------------------------------------------------------
module exp_golomb_stream_decoder #(
  parameter int VALUE_WIDTH = egsd_pkg::VALUE_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  // configuration
  input  logic                                cfg_wr_en,
  input  logic [egsd_pkg::ZCNT_WIDTH-1:0]     cfg_wr_data,
  // input beats
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [7:0]                          data_byte,
  input  logic                                end_of_stream,
  // result beats
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [egsd_pkg::OUT_WIDTH-1:0]      unsigned_value,
  output logic signed [egsd_pkg::OUT_WIDTH-1:0] signed_value,
  output logic [1:0]                          status,
  output logic                                last
);

  localparam logic [egsd_pkg::ZCNT_WIDTH-1:0] LIMIT_CAP =
    egsd_pkg::ZCNT_WIDTH'(VALUE_WIDTH - 1);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_BITS  = 4'b0010,
    S_TAIL  = 4'b0100,
    S_FLUSH = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;

  logic [egsd_pkg::ZCNT_WIDTH-1:0] max_prefix_zeros;
  logic [egsd_pkg::ZCNT_WIDTH-1:0] limit;

  // byte being worked on
  logic [7:0] shreg;
  logic       eos;
  logic [2:0] bit_cnt;

  // newest result of the byte waits here until we know whether it is the last
  logic                   pend_valid;
  logic [VALUE_WIDTH-1:0] pend_acc;
  egsd_pkg::status_t      pend_status;

  egsd_pkg::ctl_t          ctl;
  egsd_pkg::evt_t          evt;
  logic [VALUE_WIDTH-1:0]  res_acc;

  logic in_fire;
  logic out_free;
  logic step_ok;
  logic move;
  logic move_last;

  logic [egsd_pkg::OUT_WIDTH-1:0] acc_ext;
  logic [egsd_pkg::OUT_WIDTH-1:0] acc_half;
  logic [egsd_pkg::OUT_WIDTH-1:0] uval;
  logic [egsd_pkg::OUT_WIDTH-1:0] sval;

  // Cap the limit so every code number fits in VALUE_WIDTH bits.
  assign limit = (max_prefix_zeros > LIMIT_CAP) ? LIMIT_CAP : max_prefix_zeros;

  assign in_ready = (state == S_IDLE);
  assign in_fire  = in_valid && in_ready;

  // A step may raise a result; it can only go ahead if the pending slot can
  // drain into the output register in the same cycle.
  assign out_free = !out_valid || out_ready;
  assign step_ok  = !pend_valid || out_free;

  assign ctl.bit_step = (state == S_BITS) && step_ok;
  assign ctl.eos_step = (state == S_TAIL) && step_ok && eos;
  assign ctl.bit_val  = shreg[7];

  egsd_bit_dec #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_bit_dec (
    .clk     (clk),
    .rst     (rst),
    .ctl     (ctl),
    .limit   (limit),
    .evt     (evt),
    .res_acc (res_acc)
  );

  // Advance the pending result to the output when a newer one displaces it,
  // or, flagged as last, when the byte is done.
  assign move_last = (state == S_FLUSH) && pend_valid && out_free;
  assign move      = (pend_valid && evt.valid) || move_last;

  // Format: acc = 2^z + suffix, code = acc - 1. For se(v), odd code means
  // even acc and gives acc/2; even code means odd acc and gives -(acc/2).
  assign acc_ext  = egsd_pkg::OUT_WIDTH'(pend_acc);
  assign acc_half = acc_ext >> 1;
  assign uval     = acc_ext - egsd_pkg::OUT_WIDTH'(1);
  assign sval     = pend_acc[0] ? (~acc_half + egsd_pkg::OUT_WIDTH'(1)) : acc_half;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_fire) state_next = S_BITS;
      end
      S_BITS: begin
        if (step_ok && (bit_cnt == 3'd7)) state_next = S_TAIL;
      end
      S_TAIL: begin
        if (step_ok) state_next = S_FLUSH;
      end
      S_FLUSH: begin
        if (!pend_valid || out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      max_prefix_zeros <= egsd_pkg::MAX_PREFIX_RESET;
      pend_valid       <= 1'b0;
      out_valid        <= 1'b0;
      bit_cnt          <= '0;
    end else begin
      state <= state_next;
      if (cfg_wr_en) max_prefix_zeros <= cfg_wr_data;

      if (in_fire) begin
        bit_cnt <= '0;
      end else if (ctl.bit_step) begin
        bit_cnt <= bit_cnt + 1'b1;
      end

      // pending slot: load on a new result, drop when flushed as last
      if (evt.valid) begin
        pend_valid <= 1'b1;
      end else if (move_last) begin
        pend_valid <= 1'b0;
      end

      // output register: hold until taken
      if (move) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end

    if (in_fire) begin
      shreg <= data_byte;
      eos   <= end_of_stream;
    end else if (ctl.bit_step) begin
      shreg <= {shreg[6:0], 1'b0};
    end

    if (evt.valid) begin
      pend_acc    <= res_acc;
      pend_status <= evt.status;
    end

    if (move) begin
      status <= pend_status;
      last   <= move_last;
      if (pend_status == egsd_pkg::ST_OK) begin
        unsigned_value <= uval;
        signed_value   <= sval;
      end else begin
        unsigned_value <= '0;
        signed_value   <= '0;
      end
    end
  end

endmodule

>>> tb/exp_golomb_stream_decoder_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// exp_golomb_stream_decoder_tb
// Self-checking bench for the byte-fed order-0 Exp-Golomb decoder. A directed
// table covers the extremes, the error codes and the limit settings. Random
// code streams then run under several idling patterns. Each result beat is
// checked against a bit-serial model in the bench or a result typed by hand.
// ----------------------------------------------------------------------------
module exp_golomb_stream_decoder_tb;

  localparam int CYCLE_LIMIT    = 200_000;
  localparam int SETTLE_CYCLES  = 30;   // margin for the last byte to pass through the block
  localparam int RAND_PHASES    = 8;
  localparam int BEATS_PER_PHASE = 11;

  // One decoded result as it appears on the output port.
  typedef struct packed {
    logic [31:0]       uval;
    logic [31:0]       sval;
    egsd_pkg::status_t st;
    logic              fin;
  } code_result_t;

  // One row of the directed table: either a limit write or an input byte,
  // optionally with its single result typed in by hand.
  typedef struct packed {
    logic         is_cfg;
    logic [4:0]   cfg;
    logic [7:0]   db;
    logic         eos;
    logic         typed;
    code_result_t want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst;

  logic        cfg_wr_en;
  logic [4:0]  cfg_wr_data;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  data_byte;
  logic        end_of_stream;
  logic        out_valid;
  logic        out_ready;
  logic [31:0] unsigned_value;
  logic signed [31:0] signed_value;
  logic [1:0]  status;
  logic        last;

  exp_golomb_stream_decoder uut (
    .clk            (clk),
    .rst            (rst),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .data_byte      (data_byte),
    .end_of_stream  (end_of_stream),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .unsigned_value (unsigned_value),
    .signed_value   (signed_value),
    .status         (status),
    .last           (last)
  );

  // 2 ns period
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Decode model state: a private copy of the decoder registers and the limit.
  // --------------------------------------------------------------------------
  logic        dec_in_suffix;
  logic [4:0]  dec_zeros;
  logic [4:0]  dec_left;
  logic [31:0] dec_acc;
  logic [4:0]  prefix_limit;

  code_result_t step_res [8];       // results of the byte being decoded
  code_result_t pending_codes [$];  // results still owed by the block
  stim_row_t    stim_rows [$];
  logic         stream_bits [$];    // random code stream, oldest bit first

  int idle_pct;
  int stall_pct;
  int errors;
  int beats_in;
  int beats_out;
  int cycle_count;

  function automatic code_result_t make_result(input logic [31:0] code,
                                               input egsd_pkg::status_t st);
    code_result_t r;
    r.uval = 32'd0;
    r.sval = 32'd0;
    r.st   = st;
    r.fin  = 1'b0;
    if (st == egsd_pkg::ST_OK) begin
      r.uval = code;
      // odd codes map to positive values, even codes to non-positive ones
      if (code[0]) begin
        r.sval = 32'(({1'b0, code} + 33'd1) >> 1);
      end else begin
        r.sval = 32'd0 - (code >> 1);
      end
    end
    return r;
  endfunction

  function automatic void clear_decoder();
    dec_in_suffix = 1'b0;
    dec_zeros     = 5'd0;
    dec_left      = 5'd0;
    dec_acc       = 32'd0;
  endfunction

  function automatic logic [31:0] code_number();
    logic [63:0] v;
    v = {32'd0, dec_acc} + (64'd1 << dec_zeros) - 64'd1;
    return v[31:0];
  endfunction

  // Walk one byte MSB first through the decoder; fill step_res, return count.
  function automatic int decode_byte(input logic [7:0] db, input logic eos);
    int n;
    int i;
    logic bt;
    n = 0;
    // A 5-bit limit never exceeds VALUE_WIDTH-1, so no capping is needed.
    for (i = 7; i >= 0; i--) begin
      bt = db[i];
      if (dec_in_suffix) begin
        dec_acc  = {dec_acc[30:0], bt};
        dec_left = dec_left - 5'd1;
        if (dec_left == 5'd0) begin
          step_res[n] = make_result(code_number(), egsd_pkg::ST_OK);
          n++;
          clear_decoder();
        end
      end else if (!bt) begin
        if (dec_zeros >= prefix_limit) begin
          step_res[n] = make_result(32'd0, egsd_pkg::ST_PREFIX);
          n++;
          clear_decoder();
        end else begin
          dec_zeros = dec_zeros + 5'd1;
        end
      end else if (dec_zeros == 5'd0) begin
        step_res[n] = make_result(code_number(), egsd_pkg::ST_OK);
        n++;
        clear_decoder();
      end else begin
        dec_in_suffix = 1'b1;
        dec_left      = dec_zeros;
        dec_acc       = 32'd0;
      end
    end
    if (eos) begin
      if (dec_in_suffix || dec_zeros != 5'd0) begin
        step_res[n] = make_result(32'd0, egsd_pkg::ST_TRUNC);
        n++;
      end
      clear_decoder();
    end
    if (n > 0) step_res[n-1].fin = 1'b1;
    return n;
  endfunction

  // --------------------------------------------------------------------------
  // Directed table builders
  // --------------------------------------------------------------------------
  task automatic cfg_row(input logic [4:0] v);
    stim_row_t r;
    r = '0;
    r.is_cfg = 1'b1;
    r.cfg    = v;
    stim_rows.push_back(r);
  endtask

  task automatic byte_row(input logic [7:0] db, input logic eos);
    stim_row_t r;
    r = '0;
    r.db  = db;
    r.eos = eos;
    stim_rows.push_back(r);
  endtask

  // Row whose one result is obvious; last is always set on it.
  task automatic typed_row(input logic [7:0] db, input logic eos, input logic [31:0] uv,
                           input logic [31:0] sv, input egsd_pkg::status_t st);
    stim_row_t r;
    r = '0;
    r.db        = db;
    r.eos       = eos;
    r.typed     = 1'b1;
    r.want.uval = uv;
    r.want.sval = sv;
    r.want.st   = st;
    r.want.fin  = 1'b1;
    stim_rows.push_back(r);
  endtask

  // --------------------------------------------------------------------------
  // Driving
  // --------------------------------------------------------------------------

  // Present one byte, hold it until accepted, then book its results.
  task automatic send_byte(input logic [7:0] db, input logic eos, input logic typed,
                           input code_result_t want);
    int n;
    int k;
    @(negedge clk);
    // idle the sender at random before the beat
    while ($urandom_range(99) < idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid      = 1'b1;
    data_byte     = db;
    end_of_stream = eos;
    do @(posedge clk); while (!in_ready);
    // beat accepted at this edge: advance the model
    n = decode_byte(db, eos);
    if (typed) begin
      pending_codes.push_back(want);
    end else begin
      for (k = 0; k < n; k++) pending_codes.push_back(step_res[k]);
    end
    beats_in++;
  endtask

  // Drop valid and wait until the block owes nothing and has gone quiet.
  task automatic settle();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_codes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_limit(input logic [4:0] v);
    @(negedge clk);
    cfg_wr_en   = 1'b1;
    cfg_wr_data = v;
    @(negedge clk);
    cfg_wr_en    = 1'b0;
    prefix_limit = v;
  endtask

  // Append one code to the random stream; a few are made too long on purpose.
  task automatic append_code(input int lim);
    int z;
    int r;
    int k;
    r = $urandom_range(99);
    if (r < 5) begin
      // one zero past the limit: the block flags it and restarts
      for (k = 0; k <= lim; k++) stream_bits.push_back(1'b0);
    end else begin
      if (r < 15) z = $urandom_range(lim, 0);
      else        z = $urandom_range((lim < 6) ? lim : 6, 0);
      for (k = 0; k < z; k++) stream_bits.push_back(1'b0);
      stream_bits.push_back(1'b1);
      for (k = 0; k < z; k++) stream_bits.push_back(1'($urandom_range(1, 0)));
    end
  endtask

  // Next random byte: mostly cut from well-formed codes, some plain noise.
  task automatic next_stream_byte(output logic [7:0] db, output logic eos);
    int k;
    if ($urandom_range(99) < 10) begin
      db = 8'($urandom_range(255, 0));
    end else begin
      while (stream_bits.size() < 8) append_code(int'(prefix_limit));
      for (k = 7; k >= 0; k--) db[k] = stream_bits.pop_front();
    end
    eos = ($urandom_range(99) < 8);
    // the block clears its decoder state at end of stream, so drop the rest of the code
    if (eos) stream_bits.delete();
  endtask

  // --------------------------------------------------------------------------
  // Receiver: stall at random, compare every result beat with the oldest
  // expectation.
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    out_ready = ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    code_result_t want;
    if (!rst && out_valid && out_ready) begin
      beats_out++;
      if (pending_codes.size() == 0) begin
        $error("unexpected result beat: unsigned_value %0h status %0d",
               unsigned_value, status);
        errors++;
      end else begin
        want = pending_codes.pop_front();
        if (unsigned_value !== want.uval) begin
          $error("unsigned_value: expected %0h, got %0h", want.uval, unsigned_value);
          errors++;
        end
        if (signed_value !== want.sval) begin
          $error("signed_value: expected %0h, got %0h", want.sval, signed_value);
          errors++;
        end
        if (status !== want.st) begin
          $error("status: expected %0d, got %0d", want.st, status);
          errors++;
        end
        if (last !== want.fin) begin
          $error("last: expected %0b, got %0b", want.fin, last);
          errors++;
        end
      end
    end
  end

  // Hard stop if the block hangs.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    stim_row_t    row;
    code_result_t none;
    logic [7:0]   db;
    logic         eos;
    logic [4:0]   lims [RAND_PHASES];
    int           p;
    int           k;

    // every input known from time zero
    rst           = 1'b1;
    cfg_wr_en     = 1'b0;
    cfg_wr_data   = 5'd0;
    in_valid      = 1'b0;
    data_byte     = 8'd0;
    end_of_stream = 1'b0;
    out_ready     = 1'b0;
    idle_pct      = 0;
    stall_pct     = 0;
    errors        = 0;
    beats_in      = 0;
    beats_out     = 0;
    cycle_count   = 0;
    none          = '0;
    prefix_limit  = egsd_pkg::MAX_PREFIX_RESET;
    clear_decoder();

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed table. Start from the reset limit, then write it explicitly.
    cfg_row(5'd31);
    // all zeros closed by end of stream: a bare truncation
    typed_row(8'h00, 1'b1, 32'd0, 32'd0, egsd_pkg::ST_TRUNC);
    // eight one-bit codes in one byte
    byte_row(8'hFF, 1'b0);
    // widest code: 31 zeros, a one, 31 ones in the suffix
    byte_row(8'h00, 1'b0);
    byte_row(8'h00, 1'b0);
    byte_row(8'h00, 1'b0);
    byte_row(8'h01, 1'b0);
    byte_row(8'hFF, 1'b0);
    byte_row(8'hFF, 1'b0);
    byte_row(8'hFF, 1'b0);
    typed_row(8'hFE, 1'b0, 32'hFFFF_FFFE, 32'h8000_0001, egsd_pkg::ST_OK);
    // finish the pending code, then truncate on end of stream
    byte_row(8'h80, 1'b1);
    // 32 zeros: one past the limit gives a prefix error
    byte_row(8'h00, 1'b0);
    byte_row(8'h00, 1'b0);
    byte_row(8'h00, 1'b0);
    typed_row(8'h00, 1'b0, 32'd0, 32'd0, egsd_pkg::ST_PREFIX);
    // code crossing a byte boundary, then a clean end of stream
    byte_row(8'h60, 1'b0);
    byte_row(8'h5A, 1'b1);
    // end of stream in the middle of a suffix
    typed_row(8'h07, 1'b1, 32'd0, 32'd0, egsd_pkg::ST_TRUNC);
    // tightest nonzero limit
    cfg_row(5'd1);
    byte_row(8'h24, 1'b0);
    byte_row(8'h5F, 1'b1);
    // limit of zero: every leading zero is an error
    cfg_row(5'd0);
    byte_row(8'h7F, 1'b0);
    byte_row(8'hFF, 1'b1);
    byte_row(8'h00, 1'b1);

    for (k = 0; k < stim_rows.size(); k++) begin
      row = stim_rows[k];
      if (row.is_cfg) begin
        settle();
        write_limit(row.cfg);
      end else begin
        send_byte(row.db, row.eos, row.typed, row.want);
      end
    end

    // Random phases: cycle the limit and the idling pattern.
    lims[0] = 5'd31;
    lims[1] = 5'd1;
    lims[2] = 5'd0;
    lims[3] = 5'($urandom_range(30, 2));
    lims[4] = 5'd31;
    lims[5] = 5'($urandom_range(30, 2));
    lims[6] = 5'd1;
    lims[7] = 5'd31;
    for (p = 0; p < RAND_PHASES; p++) begin
      settle();
      write_limit(lims[p]);
      case (p % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 66; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 66; end
        default: begin idle_pct = 25; stall_pct = 25; end
      endcase
      stream_bits.delete();
      repeat (BEATS_PER_PHASE) begin
        next_stream_byte(db, eos);
        send_byte(db, eos, 1'b0, none);
      end
    end

    // Hold off until every owed result is out, then watch for strays.
    settle();

    $display("Run covered %0d input beats and %0d result beats", beats_in, beats_out);
    $display("over %0d prefix limits and four idling patterns", RAND_PHASES + 3);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
